### design/uewc_pkg.sv
// ============================================================================
// Ultrasonic echo width capture package
// Shared constants, codes and the stage-to-stage bundle of the echo width
// capture pipeline.
// ============================================================================
`default_nettype none

package uewc_pkg;

  // Channel and counter geometry.
  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int CNT_W        = 16;
  localparam int WIDTH_W      = 32;
  localparam int KEEP_W       = 9;
  localparam int EN_W         = 4;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = KEEP_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_KEEP    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 1'd1;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 9'd148;
  localparam logic [KEEP_W-1:0] KEEP_FULL  = 9'd256;
  localparam logic [EN_W-1:0]   EN_RESET   = 4'hF;

  // Input action codes.
  localparam logic [1:0] ACT_WRAP    = 2'd0;
  localparam logic [1:0] ACT_CAPTURE = 2'd1;
  localparam logic [1:0] ACT_TRIGGER = 2'd2;

  // Channel stage codes.
  localparam logic [1:0] ST_ECHOED    = 2'd0;
  localparam logic [1:0] ST_TRIGGERED = 2'd1;
  localparam logic [1:0] ST_ECHOING   = 2'd2;

  // Saturation limit of the per-channel wrap count.
  localparam logic [CNT_W-1:0] WRAP_MAX = {CNT_W{1'b1}};

  // Bundle passed from the control stage to the filter stage.
  typedef struct packed {
    logic               valid;
    logic [CH_W-1:0]    channel;
    logic               chan_ok;
    logic               do_filter;
    logic [WIDTH_W-1:0] width;
    logic [1:0]         stage;
    logic               fire;
    logic               expect_falling;
  } mid_t;

endpackage

`default_nettype wire

### design/ultrasonic_echo_width_capture.sv
// ============================================================================
// Ultrasonic echo width capture
// Four-channel echo pulse width measurement with trigger gating and a
// first-order low-pass filter on each measured width.
// ============================================================================
// Every transfer in (wrap, capture edge or trigger request) yields exactly one
// result transfer through the input, stage and result registers, and a new
// transfer is taken every cycle while the result side keeps up. Of the two
// stages, the control stage reads and writes the channel state and the filter
// stage holds the single 33x10 multiplier of the smoothing blend. Configuration
// writes take effect at once and must be made while no transfer is in flight.
`default_nettype none

module ultrasonic_echo_width_capture
  import uewc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_action,
  input  wire logic [CH_W-1:0]       in_channel,
  input  wire logic [CNT_W-1:0]      in_capture_count,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CH_W-1:0]            out_channel,
  output logic [WIDTH_W-1:0]         out_echo_time,
  output logic [1:0]                 out_stage,
  output logic                       out_measurement_done,
  output logic                       out_trigger_fire,
  output logic                       out_expect_falling
);

  logic [KEEP_W-1:0] filter_keep_r;
  logic [EN_W-1:0]   chan_en_r;
  logic              in_ready;
  logic              mid_ready;
  mid_t              mid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_keep_r <= KEEP_RESET;
      chan_en_r     <= EN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_KEEP:    filter_keep_r <= cfg_data;
        CFG_CHANNEL_ENABLE: chan_en_r     <= cfg_data[EN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  // Event decode and channel state.
  uewc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_channel       (in_channel),
    .in_capture_count (in_capture_count),
    .chan_en          (chan_en_r),
    .mid_ready        (mid_ready),
    .mid              (mid)
  );

  // Width smoothing and result register.
  uewc_filter u_filter (
    .clk                  (clk),
    .rst_n                (rst_n),
    .mid                  (mid),
    .mid_ready            (mid_ready),
    .filter_keep          (filter_keep_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_channel          (out_channel),
    .out_echo_time        (out_echo_time),
    .out_stage            (out_stage),
    .out_measurement_done (out_measurement_done),
    .out_trigger_fire     (out_trigger_fire),
    .out_expect_falling   (out_expect_falling)
  );

endmodule

`default_nettype wire

### design/uewc_ctrl.sv
// ============================================================================
// Echo capture control stage
// Registers the incoming event, updates the per-channel edge polarity, stage,
// wrap and rise counts, and computes the raw echo width on a falling edge.
// ============================================================================
`default_nettype none

module uewc_ctrl
  import uewc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic [CH_W-1:0]   in_channel,
  input  wire logic [CNT_W-1:0]  in_capture_count,
  input  wire logic [EN_W-1:0]   chan_en,
  input  wire logic              mid_ready,
  output mid_t                   mid
);

  // Input register.
  logic             in_v_r;
  logic [1:0]       act_r;
  logic [CH_W-1:0]  ch_r;
  logic [CNT_W-1:0] cnt_r;

  // Per-channel state.
  logic [NUM_CHANNELS-1:0] waiting_r;
  logic [NUM_CHANNELS-1:0] waiting_nxt;
  logic [1:0]       stage_r   [NUM_CHANNELS];
  logic [1:0]       stage_nxt [NUM_CHANNELS];
  logic [CNT_W-1:0] wrap_r    [NUM_CHANNELS];
  logic [CNT_W-1:0] wrap_nxt  [NUM_CHANNELS];
  logic [CNT_W-1:0] rise_r    [NUM_CHANNELS];
  logic [CNT_W-1:0] rise_nxt  [NUM_CHANNELS];

  mid_t mid_r;
  mid_t mid_nxt;

  logic               chan_ok;
  logic               enabled;
  logic               is_capture;
  logic               is_trigger;
  logic [WIDTH_W-1:0] total;
  logic [WIDTH_W:0]   diff;
  logic [WIDTH_W-1:0] width;
  logic               advance;

  assign in_ready = !in_v_r || mid_ready;
  assign advance  = in_v_r && mid_ready;

  // Input register: takes a transfer whenever it is empty or draining.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      act_r <= in_action;
      ch_r  <= in_channel;
      cnt_r <= in_capture_count;
    end
  end

  // Event decode.
  always_comb begin
    chan_ok    = ({1'b0, ch_r} < (CH_W + 1)'(NUM_CHANNELS));
    enabled    = chan_ok && chan_en[ch_r];
    is_capture = 1'b0;
    is_trigger = 1'b0;
    unique case (act_r)
      ACT_CAPTURE: is_capture = enabled;
      ACT_TRIGGER: is_trigger = enabled;
      default: ;
    endcase
  end

  // Raw width: fall plus whole counter periods minus rise, zero if negative.
  always_comb begin
    total = {wrap_r[ch_r], cnt_r};
    diff  = {1'b0, total} - {{(WIDTH_W + 1 - CNT_W){1'b0}}, rise_r[ch_r]};
    width = diff[WIDTH_W] ? '0 : diff[WIDTH_W-1:0];
  end

  // Next per-channel state.
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      waiting_nxt[c] = waiting_r[c];
      stage_nxt[c]   = stage_r[c];
      wrap_nxt[c]    = wrap_r[c];
      rise_nxt[c]    = rise_r[c];
      if (act_r == ACT_WRAP) begin
        if (wrap_r[c] != WRAP_MAX) begin
          wrap_nxt[c] = wrap_r[c] + 1'b1;
        end
      end else if (ch_r == CH_W'(c)) begin
        if (is_capture) begin
          if (!waiting_r[c]) begin
            rise_nxt[c]    = cnt_r;
            wrap_nxt[c]    = '0;
            waiting_nxt[c] = 1'b1;
            stage_nxt[c]   = ST_ECHOING;
          end else begin
            waiting_nxt[c] = 1'b0;
            stage_nxt[c]   = ST_ECHOED;
          end
        end else if (is_trigger && stage_r[c] == ST_ECHOED) begin
          stage_nxt[c] = ST_TRIGGERED;
        end
      end
    end
  end

  // Bundle for the filter stage.
  always_comb begin
    mid_nxt.valid          = in_v_r;
    mid_nxt.channel        = ch_r;
    mid_nxt.chan_ok        = chan_ok;
    mid_nxt.do_filter      = is_capture && waiting_r[ch_r];
    mid_nxt.width          = width;
    mid_nxt.stage          = chan_ok ? stage_nxt[ch_r] : ST_ECHOED;
    mid_nxt.fire           = is_trigger && (stage_r[ch_r] == ST_ECHOED);
    mid_nxt.expect_falling = chan_ok && waiting_nxt[ch_r];
  end

  // Channel state is committed as the item moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        stage_r[c] <= ST_ECHOED;
        wrap_r[c]  <= '0;
        rise_r[c]  <= '0;
      end
    end else if (advance) begin
      waiting_r <= waiting_nxt;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        stage_r[c] <= stage_nxt[c];
        wrap_r[c]  <= wrap_nxt[c];
        rise_r[c]  <= rise_nxt[c];
      end
    end
  end

  // Stage register toward the filter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
    end else if (mid_ready) begin
      mid_r.valid <= in_v_r;
    end
    if (advance) begin
      mid_r.channel        <= mid_nxt.channel;
      mid_r.chan_ok        <= mid_nxt.chan_ok;
      mid_r.do_filter      <= mid_nxt.do_filter;
      mid_r.width          <= mid_nxt.width;
      mid_r.stage          <= mid_nxt.stage;
      mid_r.fire           <= mid_nxt.fire;
      mid_r.expect_falling <= mid_nxt.expect_falling;
    end
  end

  assign mid = mid_r;

endmodule

`default_nettype wire

### design/uewc_filter.sv
// ============================================================================
// Echo width low-pass filter stage
// Holds the filtered width of every channel, blends in a new raw width with
// one multiply, and drives the result register.
// ============================================================================
`default_nettype none

module uewc_filter
  import uewc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  mid_t                    mid,
  output logic                    mid_ready,
  input  wire logic [KEEP_W-1:0]  filter_keep,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CH_W-1:0]         out_channel,
  output logic [WIDTH_W-1:0]      out_echo_time,
  output logic [1:0]              out_stage,
  output logic                    out_measurement_done,
  output logic                    out_trigger_fire,
  output logic                    out_expect_falling
);

  localparam int PROD_W = WIDTH_W + 1 + KEEP_W + 1;

  logic [WIDTH_W-1:0] filt_r [NUM_CHANNELS];

  logic                      out_valid_r;
  logic [CH_W-1:0]           channel_r;
  logic [WIDTH_W-1:0]        echo_r;
  logic [1:0]                stage_r;
  logic                      done_r;
  logic                      fire_r;
  logic                      expect_r;

  logic [KEEP_W-1:0]         keep;
  logic [KEEP_W-1:0]         fresh_wt;
  logic [WIDTH_W-1:0]        old;
  logic signed [WIDTH_W:0]   delta;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  sum;
  logic [WIDTH_W-1:0]        blended;
  logic [WIDTH_W-1:0]        echo_nxt;
  logic                      load;

  assign mid_ready = !out_valid_r || !out_stall;
  assign load      = mid.valid && mid_ready;

  // new = (old*keep + fresh*(256-keep)) >> 8 = (old*256 + (fresh-old)*(256-keep)) >> 8.
  always_comb begin
    keep     = filter_keep[KEEP_W-1] ? KEEP_FULL : filter_keep;
    fresh_wt = KEEP_FULL - keep;
    old      = filt_r[mid.channel];
    delta    = $signed({1'b0, mid.width}) - $signed({1'b0, old});
    prod     = $signed({{(PROD_W - WIDTH_W - 1){delta[WIDTH_W]}}, delta})
             * $signed({{(PROD_W - KEEP_W){1'b0}}, fresh_wt});
    sum      = $signed({{(PROD_W - WIDTH_W - 8){1'b0}}, old, 8'd0}) + prod;
    blended  = sum[WIDTH_W+7:8];
  end

  // Reported width follows the update made by this item.
  always_comb begin
    if (!mid.chan_ok) begin
      echo_nxt = '0;
    end else if (mid.do_filter) begin
      echo_nxt = blended;
    end else begin
      echo_nxt = old;
    end
  end

  // Filtered width per channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        filt_r[c] <= '0;
      end
    end else if (load && mid.do_filter && mid.chan_ok) begin
      filt_r[mid.channel] <= blended;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mid_ready) begin
      out_valid_r <= mid.valid;
    end
    if (load) begin
      channel_r <= mid.channel;
      echo_r    <= echo_nxt;
      stage_r   <= mid.stage;
      done_r    <= mid.do_filter;
      fire_r    <= mid.fire;
      expect_r  <= mid.expect_falling;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_channel          = channel_r;
  assign out_echo_time        = echo_r;
  assign out_stage            = stage_r;
  assign out_measurement_done = done_r;
  assign out_trigger_fire     = fire_r;
  assign out_expect_falling   = expect_r;

endmodule

`default_nettype wire

### design/uewc_checker.sv
// ============================================================================
// Echo width capture port checker
// Watches the result channel of the echo width capture block for a stalled result
// that is dropped, and for flag and stage combinations that the channel logic can never produce.
// ============================================================================
`default_nettype none

module uewc_checker
  import uewc_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_valid,
  input wire logic         out_stall,
  input wire logic [1:0]   out_stage,
  input wire logic         out_measurement_done,
  input wire logic         out_trigger_fire,
  input wire logic         out_expect_falling
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One event cannot both finish a width and fire a trigger.
  a_done_fire_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_measurement_done && out_trigger_fire))
    else $error("measurement and trigger in one result");

  // A fired trigger leaves the channel in the triggered stage.
  a_fire_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_fire |-> out_stage == ST_TRIGGERED)
    else $error("trigger fired without entering triggered stage");

  // A completed width returns the channel to idle, armed for a rising edge.
  a_done_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_measurement_done |-> out_stage == ST_ECHOED && !out_expect_falling)
    else $error("completed width left channel busy");

  // Waiting for a falling edge always means an echo is in progress.
  a_falling_echoing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_expect_falling |-> out_stage == ST_ECHOING)
    else $error("falling edge armed outside echo");

endmodule

bind ultrasonic_echo_width_capture uewc_checker u_uewc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_stage            (out_stage),
  .out_measurement_done (out_measurement_done),
  .out_trigger_fire     (out_trigger_fire),
  .out_expect_falling   (out_expect_falling)
);

`default_nettype wire
